// File: hdl/qn_pkg.sv
`timescale 1ns / 1ps

package qn_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int LANES      = 4;

  localparam int SQ_W  = 2 * COMP_WIDTH;
  localparam int SUM_W = SQ_W + 2;
  // room for n^2*S, the cross term and the shifted S while testing a bit
  localparam int ACC_W = SUM_W + 2 * FRAC_BITS + 2;
  localparam int ROOT_W = FRAC_BITS + 1;

  // one item in flight through the square root chain
  typedef struct packed {
    logic                               vld;
    logic                               zero;
    logic [LANES-1:0]                   neg;
    logic [LANES-1:0][ACC_W-1:0]        rr;   // mag^2 << 2F
    logic [LANES-1:0][ACC_W-1:0]        pp;   // n^2 * S
    logic [LANES-1:0][ACC_W-1:0]        tt;   // n * S << (b+1)
    logic [ACC_W-1:0]                   qq;   // S << 2b
    logic [LANES-1:0][ROOT_W-1:0]       nn;
  } qn_iter_t;

endpackage

// File: hdl/qn_root_stage.sv
`timescale 1ns / 1ps

module qn_root_stage
  import qn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  qn_iter_t stg_i,
  output qn_iter_t stg_o
);

  qn_iter_t stg_nxt;
  qn_iter_t stg_r;

  logic [LANES-1:0][ACC_W-1:0] cand;
  logic [LANES-1:0][ACC_W-1:0] tsum;
  logic [LANES-1:0]            take;

  // decide one result bit in every lane: (n + 2^b)^2 S <= mag^2 2^2F
  always_comb begin
    stg_nxt = stg_i;
    for (int i = 0; i < LANES; i++) begin
      cand[i] = stg_i.pp[i] + stg_i.tt[i] + stg_i.qq;
      take[i] = (cand[i] <= stg_i.rr[i]);
      tsum[i] = take[i] ? (stg_i.tt[i] + (stg_i.qq << 1)) : stg_i.tt[i];
      stg_nxt.pp[i] = take[i] ? cand[i] : stg_i.pp[i];
      stg_nxt.tt[i] = tsum[i] >> 1;
      stg_nxt.nn[i] = {stg_i.nn[i][ROOT_W-2:0], take[i]};
    end
    stg_nxt.qq = stg_i.qq >> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else begin
      stg_r.vld <= stg_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_r.zero <= stg_nxt.zero;
    stg_r.neg  <= stg_nxt.neg;
    stg_r.rr   <= stg_nxt.rr;
    stg_r.pp   <= stg_nxt.pp;
    stg_r.tt   <= stg_nxt.tt;
    stg_r.qq   <= stg_nxt.qq;
    stg_r.nn   <= stg_nxt.nn;
  end

  assign stg_o = stg_r;

endmodule

// File: hdl/quaternion_normalize.sv
`timescale 1ns / 1ps
// Quaternion normalizer, Q2.14 in, Q2.14 out, truncated toward zero.
// Input: drive in_q0..in_q3 and pulse start; a transfer happens at each
// rising edge with start high and busy low. busy is always low, so a new
// quaternion may be given in every cycle.
// Output: out_strobe is high for one cycle with out_n0..out_n3 and
// out_zero_magnitude. The result of a transfer passes the square, sum,
// root chain and output registers in order and is taken at the edge
// ending the strobe cycle. Throughput is one quaternion per cycle.
// Latency is set by the square root chain: one register stage per result
// bit (FRAC_BITS + 1), plus a square stage, a sum stage and the output
// register.
// An all-zero input gives zero outputs with out_zero_magnitude set.
// The receiver cannot stall; results leave on the fixed schedule.
// Synchronous reset empties the pipeline; items in flight are dropped.
module quaternion_normalize
  import qn_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COMP_WIDTH-1:0] in_q0,
  input  logic signed [COMP_WIDTH-1:0] in_q1,
  input  logic signed [COMP_WIDTH-1:0] in_q2,
  input  logic signed [COMP_WIDTH-1:0] in_q3,
  output logic                         out_strobe,
  output logic signed [COMP_WIDTH-1:0] out_n0,
  output logic signed [COMP_WIDTH-1:0] out_n1,
  output logic signed [COMP_WIDTH-1:0] out_n2,
  output logic signed [COMP_WIDTH-1:0] out_n3,
  output logic                         out_zero_magnitude
);

  localparam int LATENCY = FRAC_BITS + 3;
  localparam logic signed [COMP_WIDTH-1:0] UNIT = COMP_WIDTH'(1) << FRAC_BITS;

  logic [LANES-1:0][COMP_WIDTH-1:0] q_in;
  logic [LANES-1:0][COMP_WIDTH-1:0] mag;
  logic [LANES-1:0]                 neg;
  logic [LANES-1:0][SQ_W-1:0]       sq;

  logic                             v1_r;
  logic [LANES-1:0]                 neg1_r;
  logic [LANES-1:0][SQ_W-1:0]       sq1_r;

  logic [SUM_W-1:0] sum;
  qn_iter_t         s2_nxt;
  qn_iter_t         s2_r;
  qn_iter_t         stg [FRAC_BITS+2];

  logic [LANES-1:0][COMP_WIDTH-1:0] res_nxt;
  logic [LANES-1:0][COMP_WIDTH-1:0] res_r;
  logic                             strobe_r;
  logic                             zero_r;

  assign busy = 1'b0;
  assign q_in = {in_q3, in_q2, in_q1, in_q0};

  // stage 1: magnitudes and squares
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      neg[i] = q_in[i][COMP_WIDTH-1];
      mag[i] = neg[i] ? (~q_in[i] + COMP_WIDTH'(1)) : q_in[i];
      sq[i]  = SQ_W'(mag[i]) * SQ_W'(mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    neg1_r <= neg;
    sq1_r  <= sq;
  end

  // stage 2: sum of squares and seed for the root chain
  always_comb begin
    sum = '0;
    for (int i = 0; i < LANES; i++) begin
      sum = sum + SUM_W'(sq1_r[i]);
    end
    s2_nxt.vld  = v1_r;
    s2_nxt.zero = (sum == '0);
    s2_nxt.neg  = neg1_r;
    for (int i = 0; i < LANES; i++) begin
      s2_nxt.rr[i] = ACC_W'(sq1_r[i]) << (2 * FRAC_BITS);
      s2_nxt.pp[i] = '0;
      s2_nxt.tt[i] = '0;
      s2_nxt.nn[i] = '0;
    end
    s2_nxt.qq = ACC_W'(sum) << (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else begin
      s2_r.vld <= s2_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_r.zero <= s2_nxt.zero;
    s2_r.neg  <= s2_nxt.neg;
    s2_r.rr   <= s2_nxt.rr;
    s2_r.pp   <= s2_nxt.pp;
    s2_r.tt   <= s2_nxt.tt;
    s2_r.qq   <= s2_nxt.qq;
    s2_r.nn   <= s2_nxt.nn;
  end

  assign stg[0] = s2_r;

  // one stage per result bit, MSB first
  for (genvar g = 0; g <= FRAC_BITS; g++) begin : g_root
    qn_root_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .stg_i (stg[g]),
      .stg_o (stg[g+1])
    );
  end

  // output stage: restore sign, force zero for a zero-length input
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (stg[FRAC_BITS+1].zero) begin
        res_nxt[i] = '0;
      end else if (stg[FRAC_BITS+1].neg[i]) begin
        res_nxt[i] = -COMP_WIDTH'(stg[FRAC_BITS+1].nn[i]);
      end else begin
        res_nxt[i] = COMP_WIDTH'(stg[FRAC_BITS+1].nn[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= stg[FRAC_BITS+1].vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    zero_r <= stg[FRAC_BITS+1].zero;
  end

  assign out_strobe         = strobe_r;
  assign out_n0             = res_r[0];
  assign out_n1             = res_r[1];
  assign out_n2             = res_r[2];
  assign out_n3             = res_r[3];
  assign out_zero_magnitude = zero_r;

  // strobe is driven high by the output register once the transfer has passed
  // the whole pipeline, so it is sampled high at the following edge
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LATENCY + 1) out_strobe)
    else $error("result missing after fixed latency");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_zero_magnitude) |->
      (out_n0 == '0 && out_n1 == '0 && out_n2 == '0 && out_n3 == '0))
    else $error("nonzero output on zero-magnitude input");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_n0 <= UNIT && out_n0 >= -UNIT &&
                    out_n1 <= UNIT && out_n1 >= -UNIT &&
                    out_n2 <= UNIT && out_n2 >= -UNIT &&
                    out_n3 <= UNIT && out_n3 >= -UNIT))
    else $error("normalized component out of unit range");

endmodule

// File: tb/sv/quaternion_normalize_checker.sv
`timescale 1ns / 1ps

module quaternion_normalize_checker
  import qn_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [COMP_WIDTH-1:0] in_q0,
  input  logic signed [COMP_WIDTH-1:0] in_q1,
  input  logic signed [COMP_WIDTH-1:0] in_q2,
  input  logic signed [COMP_WIDTH-1:0] in_q3,
  input  logic                         out_strobe,
  input  logic signed [COMP_WIDTH-1:0] out_n0,
  input  logic signed [COMP_WIDTH-1:0] out_n1,
  input  logic signed [COMP_WIDTH-1:0] out_n2,
  input  logic signed [COMP_WIDTH-1:0] out_n3,
  input  logic                         out_zero_magnitude,
  output int                           errors,
  output int                           pending
);

  typedef struct packed {
    logic [LANES-1:0][COMP_WIDTH-1:0] n;
    logic                             zero;
  } unit_quat_t;

  unit_quat_t unit_q[$];
  int         shown;

  assign pending = unit_q.size();

  // exact: largest n with n^2 * S <= mag^2 << 2F, bit by bit
  function automatic unit_quat_t normalize(logic [LANES-1:0][COMP_WIDTH-1:0] q);
    logic [COMP_WIDTH:0] mag [LANES];
    logic [LANES-1:0]    neg;
    logic [127:0]        sum_sq, rhs, lhs;
    logic [ROOT_W-1:0]   root, cand;
    unit_quat_t          r;
    sum_sq = '0;
    for (int i = 0; i < LANES; i++) begin
      neg[i] = q[i][COMP_WIDTH-1];
      mag[i] = neg[i] ? ({1'b0, ~q[i]} + (COMP_WIDTH+1)'(1)) : {1'b0, q[i]};
      sum_sq += mag[i] * mag[i];
    end
    r = '0;
    if (sum_sq == 0) begin
      r.zero = 1'b1;
      return r;
    end
    for (int i = 0; i < LANES; i++) begin
      rhs  = (128'(mag[i]) * mag[i]) << (2 * FRAC_BITS);
      root = '0;
      for (int b = FRAC_BITS; b >= 0; b--) begin
        cand = root | (ROOT_W'(1) << b);
        lhs  = 128'(cand) * cand * sum_sq;
        if (lhs <= rhs) root = cand;
      end
      r.n[i] = neg[i] ? -COMP_WIDTH'(root) : COMP_WIDTH'(root);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    unit_quat_t got, want;
    if (!rst_n) begin
      errors <= 0;
      shown  = 0;
      unit_q.delete();
    end else begin
      if (start && !busy)
        unit_q.push_back(normalize({in_q3, in_q2, in_q1, in_q0}));
      if (out_strobe) begin
        got.n    = {out_n3, out_n2, out_n1, out_n0};
        got.zero = out_zero_magnitude;
        if (unit_q.size() == 0) begin
          errors <= errors + 1;
          if (shown < 10) $display("unexpected result at %0t", $time);
          shown++;
        end else begin
          want = unit_q.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            if (shown < 10)
              $display("mismatch: exp n=%0d,%0d,%0d,%0d z=%0b got n=%0d,%0d,%0d,%0d z=%0b",
                $signed(want.n[0]), $signed(want.n[1]), $signed(want.n[2]),
                $signed(want.n[3]), want.zero, out_n0, out_n1, out_n2, out_n3,
                out_zero_magnitude);
            shown++;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/quaternion_normalize_tb.sv
`timescale 1ns / 1ps

module quaternion_normalize_tb;
  import qn_pkg::*;

  localparam int LATENCY = FRAC_BITS + 3;
  localparam int CYCLE_LIMIT = 200000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic signed [COMP_WIDTH-1:0] in_q0 = '0, in_q1 = '0, in_q2 = '0, in_q3 = '0;
  logic                         out_strobe, out_zero_magnitude;
  logic signed [COMP_WIDTH-1:0] out_n0, out_n1, out_n2, out_n3;
  int                           errors, pending;
  int                           cycles = 0;

  always #6 clk = ~clk;

  quaternion_normalize DUT (.*);

  quaternion_normalize_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [COMP_WIDTH-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(COMP_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(COMP_WIDTH-1){1'b1}}};
      2:       return '0;
      3:       return COMP_WIDTH'($signed($urandom_range(0, 16)) - 8);
      default: return COMP_WIDTH'($urandom);
    endcase
  endfunction

  // one transfer; start stays high across back-to-back items
  task automatic send_quat(logic [COMP_WIDTH-1:0] a, b, c, d);
    in_q0 <= a;
    in_q1 <= b;
    in_q2 <= c;
    in_q3 <= d;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // idle gaps after about 15% of items unless calm: roughly 27% idle cycles
  task automatic idle_gap(bit calm);
    if (!calm && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  localparam logic [COMP_WIDTH-1:0] MAXP = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam logic [COMP_WIDTH-1:0] MAXN = {1'b1, {(COMP_WIDTH-1){1'b0}}};
  localparam logic [COMP_WIDTH-1:0] ONE  = COMP_WIDTH'(1) << FRAC_BITS;

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero magnitude, extremes, single-axis, equal-component cases
    send_quat('0, '0, '0, '0);
    send_quat(MAXN, MAXN, MAXN, MAXN);
    send_quat(MAXP, MAXP, MAXP, MAXP);
    send_quat(MAXN, '0, '0, '0);
    send_quat('0, MAXP, '0, '0);
    send_quat('0, '0, MAXN, '0);
    send_quat('0, '0, '0, 16'sd1);
    send_quat(ONE, '0, '0, '0);
    send_quat(-ONE, ONE, -ONE, ONE);
    send_quat(MAXN, MAXP, 16'sd1, -16'sd1);
    send_quat(16'sd1, 16'sd1, 16'sd1, 16'sd1);
    send_quat(-16'sd1, '0, '0, '0);
    send_quat(MAXP, 16'sd1, '0, '0);
    send_quat(16'sd3, 16'sd4, '0, '0);
    idle_gap(1'b0);

    for (int i = 0; i < 800; i++) begin
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      idle_gap(i >= 300 && i < 450);
    end
    start <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/qn_pkg.sv
hdl/qn_root_stage.sv
hdl/quaternion_normalize.sv
tb/sv/quaternion_normalize_checker.sv
tb/sv/quaternion_normalize_tb.sv
